// ===== hdl/flex_pkg.sv =====
package flex_pkg;

	// token kinds
	localparam logic [3:0] K_OP    = 4'd0;
	localparam logic [3:0] K_KW    = 4'd1;
	localparam logic [3:0] K_STR   = 4'd2;
	localparam logic [3:0] K_ID    = 4'd3;
	localparam logic [3:0] K_INT   = 4'd4;
	localparam logic [3:0] K_LPAR  = 4'd5;
	localparam logic [3:0] K_RPAR  = 4'd6;
	localparam logic [3:0] K_LBRK  = 4'd7;
	localparam logic [3:0] K_RBRK  = 4'd8;
	localparam logic [3:0] K_CMT   = 4'd9;
	localparam logic [3:0] K_COMMA = 4'd10;
	localparam logic [3:0] K_SEMI  = 4'd11;
	localparam logic [3:0] K_EOL   = 4'd12;
	localparam logic [3:0] K_SPACE = 4'd13;
	localparam logic [3:0] K_PTR   = 4'd14;
	localparam logic [3:0] K_ERR   = 4'd15;

	// result queue
	localparam int RQ_DEPTH = 8;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef struct packed {
		logic        run_end;
		logic [15:0] length;
		logic [15:0] start;
		logic [3:0]  kind;
	} token_t;

endpackage

// ===== hdl/formula_lexer.sv =====
// formula_lexer: streaming tokenizer for formula text
// slave channel: one text byte per transfer in s_tdata, s_tlast on the final
//   byte of a text; after that byte the offsets start again at zero
// master channel: one token per transfer, m_tdata = kind, start, length,
//   m_tlast set on the last token caused by one input byte
// each input byte gives zero, one or two tokens; priority is first rule wins,
//   words are checked against the operator and keyword lists in parallel
// a token decided by a byte passes the input register, then the lexer step
//   writes it into the result queue, from which it is offered; a second token
//   from the same byte is written in the same step and offered after the first
// throughput: one byte per cycle while s_tready is high; the lexer state
//   update is a single step, the eight-entry result queue soaks up two-token bytes
// s_tready drops only when the queue could not hold the tokens of the byte
//   in flight plus the next one, so a stalled receiver backs up the input
//   and nothing is lost
// after an error token the rest of the text, up to the s_tlast byte, is
//   dropped without output
// reset (arst_n low) empties the queue and puts the lexer between tokens at
//   offset zero
module formula_lexer #(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_char
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // token_kind[3:0], token_start[19:4], token_length[35:20]
	output logic        m_tlast    // run_end
);
	import flex_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_WORD = 3'd1;
	localparam logic [2:0] M_INT  = 3'd2;
	localparam logic [2:0] M_STR  = 3'd3;
	localparam logic [2:0] M_CMT  = 3'd4;
	localparam logic [2:0] M_PAIR = 3'd5;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;

	logic [2:0]    mode_q;
	logic [PB-1:0] pstart_q;
	logic [PB-1:0] plen_q;
	logic [PB-1:0] cpos_q;
	logic [7:0]    held_q;
	logic          skip_q;
	logic [8:0][7:0] prefix_q;

	logic [2:0]    nmode;
	logic [PB-1:0] npstart;
	logic [PB-1:0] nplen;
	logic [PB-1:0] ncpos;
	logic [7:0]    nheld;
	logic          nskip;
	logic          pf_we;
	logic [3:0]    pf_idx;
	logic [7:0]    pf_dat;
	logic [8:0][7:0] pf_view;
	logic          handled;
	token_t        res [2];
	logic [1:0]    res_n;

	token_t           rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q;
	logic [RQ_AW-1:0] rd_ptr_q;
	logic [RQ_AW:0]   count_q;
	logic             pop;

	function automatic logic [15:0] clip16(input logic [PB-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (v == '1) ? v : v + PB'(1);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// kind of a closing word; boundary means a character other than a digit, or end, follows
	function automatic logic [3:0] word_kind(input logic [PB-1:0] len,
			input logic [8:0][7:0] pf, input logic boundary, input logic at_end);
		logic w_not, w_and, w_or, w_where, w_fns, w_def, w_faifile, w_faiend;
		w_not = len == PB'(3) && pf[0] == "n" && pf[1] == "o" && pf[2] == "t";
		w_and = len == PB'(3) && pf[0] == "a" && pf[1] == "n" && pf[2] == "d";
		w_or  = len == PB'(2) && pf[0] == "o" && pf[1] == "r";
		w_where = len == PB'(5) && pf[0] == "w" && pf[1] == "h" && pf[2] == "e"
			&& pf[3] == "r" && pf[4] == "e";
		w_fns = len == PB'(9) && pf[0] == "f" && pf[1] == "u" && pf[2] == "n"
			&& pf[3] == "c" && pf[4] == "t" && pf[5] == "i" && pf[6] == "o"
			&& pf[7] == "n" && pf[8] == "s";
		w_def = len == PB'(3) && pf[0] == "d" && pf[1] == "e" && pf[2] == "f";
		w_faifile = len == PB'(7) && pf[0] == "f" && pf[1] == "a" && pf[2] == "i"
			&& pf[3] == "f" && pf[4] == "i" && pf[5] == "l" && pf[6] == "e";
		w_faiend = len == PB'(6) && pf[0] == "f" && pf[1] == "a" && pf[2] == "i"
			&& pf[3] == "e" && pf[4] == "n" && pf[5] == "d";
		if (len == PB'(1) && pf[0] == "d" && !at_end)
			return K_OP;
		else if (boundary && (w_not || w_and || w_or || w_where))
			return K_OP;
		else if (boundary && (w_fns || w_def || w_faifile || w_faiend))
			return K_KW;
		else
			return K_ID;
	endfunction

	assign s_tready = (count_q + (valid_s1 ? (RQ_AW+1)'(2) : '0)) <= (RQ_AW+1)'(RQ_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= s_tvalid && s_tready;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		nmode   = mode_q;
		npstart = pstart_q;
		nplen   = plen_q;
		ncpos   = cpos_q;
		nheld   = held_q;
		nskip   = skip_q;
		pf_we   = 1'b0;
		pf_idx  = '0;
		pf_dat  = char_s1;
		handled = 1'b0;
		res[0]  = '0;
		res[1]  = '0;
		res_n   = '0;
		pf_view = prefix_q;

		if (valid_s1) begin
			if (skip_q) begin
				if (last_s1) begin
					nmode = M_IDLE; npstart = '0; nplen = '0; ncpos = '0;
					nheld = '0; nskip = 1'b0;
				end
			end else begin
				unique case (mode_q)
					M_WORD: begin
						if (is_letter(char_s1) || char_s1 == "_") begin
							if (plen_q == PB'(1) && prefix_q[0] == "d" && char_s1 == "_") begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(pstart_q), K_OP};
								res_n = res_n + 2'd1;
								npstart = cpos_q;
								nplen = PB'(1);
								pf_we = 1'b1;
							end else begin
								pf_we = plen_q < PB'(9);
								pf_idx = plen_q[3:0];
								nplen = sat_inc(plen_q);
							end
							handled = 1'b1;
						end else begin
							res[res_n[0]] = '{1'b0, clip16(plen_q), clip16(pstart_q),
								word_kind(plen_q, prefix_q, !is_digit(char_s1), 1'b0)};
							res_n = res_n + 2'd1;
							nmode = M_IDLE;
						end
					end
					M_INT: begin
						if (is_digit(char_s1)) begin
							nplen = sat_inc(plen_q);
							handled = 1'b1;
						end else begin
							res[res_n[0]] = '{1'b0, clip16(plen_q), clip16(pstart_q), K_INT};
							res_n = res_n + 2'd1;
							nmode = M_IDLE;
						end
					end
					M_STR, M_CMT: begin
						nplen = sat_inc(plen_q);
						handled = 1'b1;
						if (mode_q == M_STR && char_s1 == "'") begin
							res[res_n[0]] = '{1'b0, clip16(nplen), clip16(pstart_q), K_STR};
							res_n = res_n + 2'd1;
							nmode = M_IDLE;
						end else if (mode_q == M_CMT && char_s1 == "#") begin
							res[res_n[0]] = '{1'b0, clip16(nplen), clip16(pstart_q), K_CMT};
							res_n = res_n + 2'd1;
							nmode = M_IDLE;
						end
					end
					M_PAIR: begin
						nmode = M_IDLE;
						if (held_q == "-") begin
							if (char_s1 == ">") begin
								res[res_n[0]] = '{1'b0, 16'd2, clip16(pstart_q), K_PTR};
								handled = 1'b1;
							end else begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(pstart_q), K_OP};
							end
						end else if (held_q == "!") begin
							if (char_s1 == "=") begin
								res[res_n[0]] = '{1'b0, 16'd2, clip16(pstart_q), K_OP};
							end else begin
								res[res_n[0]] = '{1'b0, 16'd0, clip16(pstart_q), K_ERR};
								nskip = 1'b1;
							end
							handled = 1'b1;
						end else begin
							if (char_s1 == "=") begin
								res[res_n[0]] = '{1'b0, 16'd2, clip16(pstart_q), K_OP};
								handled = 1'b1;
							end else begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(pstart_q), K_OP};
							end
						end
						res_n = res_n + 2'd1;
					end
					default: nmode = M_IDLE;
				endcase

				// start of a new token
				if (!handled && !nskip) begin
					if (is_letter(char_s1) || char_s1 == "_") begin
						nmode = M_WORD; npstart = cpos_q; nplen = PB'(1);
						pf_we = 1'b1; pf_idx = '0;
					end else if (is_digit(char_s1)) begin
						nmode = M_INT; npstart = cpos_q; nplen = PB'(1);
					end else begin
						unique case (char_s1)
							"'": begin
								nmode = M_STR; npstart = cpos_q; nplen = PB'(1);
							end
							"#": begin
								nmode = M_CMT; npstart = cpos_q; nplen = PB'(1);
							end
							"<", ">", "!", "-": begin
								nmode = M_PAIR; npstart = cpos_q; nplen = PB'(1);
								nheld = char_s1;
							end
							"*", "+", "^", "%", "/", "=", ".": begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_OP};
								res_n = res_n + 2'd1;
							end
							"(": begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_LPAR};
								res_n = res_n + 2'd1;
							end
							")": begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_RPAR};
								res_n = res_n + 2'd1;
							end
							"[": begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_LBRK};
								res_n = res_n + 2'd1;
							end
							"]": begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_RBRK};
								res_n = res_n + 2'd1;
							end
							",": begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_COMMA};
								res_n = res_n + 2'd1;
							end
							";": begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_SEMI};
								res_n = res_n + 2'd1;
							end
							8'h0A: begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_EOL};
								res_n = res_n + 2'd1;
							end
							8'h20, 8'h09, 8'h0D, 8'h0C: begin
								res[res_n[0]] = '{1'b0, 16'd1, clip16(cpos_q), K_SPACE};
								res_n = res_n + 2'd1;
							end
							default: begin
								res[res_n[0]] = '{1'b0, 16'd0, clip16(cpos_q), K_ERR};
								res_n = res_n + 2'd1;
								nskip = 1'b1;
								nmode = M_IDLE;
							end
						endcase
					end
				end

				// prefix as seen after this byte's write
				for (int i = 0; i < 9; i++)
					if (pf_we && pf_idx == 4'(i))
						pf_view[i] = pf_dat;

				if (last_s1) begin
					if (!nskip) begin
						unique case (nmode)
							M_WORD: begin
								res[res_n[0]] = '{1'b0, clip16(nplen), clip16(npstart),
									word_kind(nplen, pf_view, 1'b1, 1'b1)};
								res_n = res_n + 2'd1;
							end
							M_INT: begin
								res[res_n[0]] = '{1'b0, clip16(nplen), clip16(npstart), K_INT};
								res_n = res_n + 2'd1;
							end
							M_STR, M_CMT: begin
								res[res_n[0]] = '{1'b0, 16'd0, clip16(npstart), K_ERR};
								res_n = res_n + 2'd1;
							end
							M_PAIR: begin
								if (nheld == "<" || nheld == ">")
									res[res_n[0]] = '{1'b0, 16'd1, clip16(npstart), K_OP};
								else
									res[res_n[0]] = '{1'b0, 16'd0, clip16(npstart), K_ERR};
								res_n = res_n + 2'd1;
							end
							default: ;
						endcase
					end
					nmode = M_IDLE; npstart = '0; nplen = '0; ncpos = '0;
					nheld = '0; nskip = 1'b0;
				end else begin
					ncpos = sat_inc(cpos_q);
				end
			end

			if (res_n == 2'd2)
				res[1].run_end = 1'b1;
			else if (res_n == 2'd1)
				res[0].run_end = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pstart_q <= '0;
			plen_q   <= '0;
			cpos_q   <= '0;
			held_q   <= '0;
			skip_q   <= 1'b0;
		end else if (valid_s1) begin
			mode_q   <= nmode;
			pstart_q <= npstart;
			plen_q   <= nplen;
			cpos_q   <= ncpos;
			held_q   <= nheld;
			skip_q   <= nskip;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++)
			if (valid_s1 && !skip_q && pf_we && pf_idx == 4'(i))
				prefix_q[i] <= pf_dat;
	end

	// result queue
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = count_q != '0;
	assign m_tdata  = {4'b0, rq_q[rd_ptr_q].length, rq_q[rd_ptr_q].start, rq_q[rd_ptr_q].kind};
	assign m_tlast  = rq_q[rd_ptr_q].run_end;

	always_ff @(posedge clk) begin
		if (res_n != 2'd0)
			rq_q[wr_ptr_q] <= res[0];
		if (res_n == 2'd2)
			rq_q[wr_ptr_q + RQ_AW'(1)] <= res[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(res_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			count_q <= count_q + (RQ_AW+1)'(res_n) - (RQ_AW+1)'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (RQ_AW+1)'(RQ_DEPTH))
		else $error("result queue overflow");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && skip_q) |-> res_n == 2'd0)
		else $error("token emitted while skipping");

	a_err_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !skip_q && !last_s1 && res_n != 2'd0 &&
			res[res_n[1] ? 1 : 0].kind == K_ERR) |=> skip_q)
		else $error("error did not start skipping");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (cpos_q == '0 && mode_q == M_IDLE && !skip_q))
		else $error("state not cleared after end of text");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without transfer");
`endif

endmodule
